### rtl/core/bse_pkg.sv
// Shared constants and types for the button scanner with autorepeat events.
package bse_pkg;

  localparam int NUM_BUTTONS = 10;
  localparam int LEVEL_BITS  = 10;
  localparam int OFF_BUTTON  = 9;
  localparam int MENU_BUTTON = 4;
  localparam int NUM_DIRS    = 4;
  localparam int BTN_IDX_W   = $clog2(NUM_BUTTONS);

  localparam int EVENT_CODE_W = 4;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [EVENT_CODE_W-1:0] CODE_TIMER  = 4'd10;
  localparam logic [EVENT_CODE_W-1:0] CODE_USB    = 4'd11;
  localparam logic [EVENT_CODE_W-1:0] CODE_POWER  = 4'd12;
  localparam logic [EVENT_CODE_W-1:0] CODE_WAKE   = 4'd13;
  localparam logic [EVENT_CODE_W-1:0] CODE_HALT   = 4'd14;
  localparam logic [EVENT_CODE_W-1:0] CODE_SCREEN = 4'd15;

  localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_RELOAD     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFF_HOLD_LIMIT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_TIMER_ENABLE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TICK_TIMER_LIMIT  = 2'd3;

  localparam logic [7:0]  RESET_REPEAT_RELOAD    = 8'd5;
  localparam logic [15:0] RESET_OFF_HOLD_LIMIT   = 16'd30;
  localparam logic [15:0] RESET_TICK_TIMER_LIMIT = 16'd10;

  typedef struct packed {
    logic [EVENT_CODE_W-1:0] code;
    logic                    level;
    logic                    flush;
  } event_t;

endpackage

### rtl/core/button_scanner_autorepeat_events_top.sv
// Top level of the button scanner with autorepeat and event generation.
//
// One item transfer on the item channel carries one poll tick: ten active-low
// button levels, the screen state, the USB and power levels and a wake request.
// The block answers with zero or more event transfers on the event channel,
// the final one of each tick marked by last_of_tick.
// Configuration registers are written through the cfg channel while the block
// is idle; a write to the timer enable or timer limit clears the timer count.
// A tick is worked through by a small sequencer with one shared 16-bit
// increment, decrement and compare unit: it takes the item, steps through
// each button, with an extra step while button nine is held and one for a
// halt event, then runs the timer, USB and power steps and closes the tick.
// A press with the screen off ends the button steps; a wake tick sends its
// wake event and closes. Each event is held one step in a pending register so
// the last one can be marked, and leaves through an output register; a stalled
// receiver holds the sequencer only when it has a new event to place or one
// pending at the close. The next tick is taken while the last event still waits.
// Reset restores the register defaults and clears all countdowns and counts.
module button_scanner_autorepeat_events_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_ready,
  input  logic [bse_pkg::LEVEL_BITS-1:0]     button_levels,
  input  logic                               screen_on,
  input  logic                               usb_present,
  input  logic                               power_present,
  input  logic                               wake_request,
  output logic                               event_valid,
  input  logic                               event_ready,
  output logic [bse_pkg::EVENT_CODE_W-1:0]   event_code,
  output logic                               new_level,
  output logic                               flush_queue,
  output logic                               last_of_tick,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bse_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bse_pkg::CFG_DATA_W-1:0]     cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_WAKE, S_BTN, S_TIMER, S_USB, S_PWR, S_FIN
  } state_t;

  state_t state;

  logic [7:0]  repeat_reload;
  logic [15:0] off_hold_limit;
  logic        tick_timer_enable;
  logic [15:0] tick_timer_limit;

  logic [7:0]  countdown [bse_pkg::NUM_BUTTONS];
  logic [15:0] off_hold_count;
  logic [15:0] timer_count;
  logic        usb_level_seen;
  logic        power_level_seen;
  logic        levels_captured;

  logic [bse_pkg::LEVEL_BITS-1:0] levels;
  logic        screen;
  logic        usb;
  logic        pwr;
  logic [bse_pkg::BTN_IDX_W-1:0] idx;
  logic        dir_held;
  logic        off_done;
  logic        halt_due;

  bse_pkg::event_t pend;
  logic            pend_valid;

  logic [bse_pkg::NUM_BUTTONS-1:0] released_vec;
  logic        pressed;
  logic        idx_last;
  logic        idx_dir;
  logic        off_step;
  logic        menu_skip;
  logic        out_free;
  logic        can_push;
  logic        push_req;
  logic        push_ok;
  logic        fin_load;
  logic        out_load;
  bse_pkg::event_t push_event;

  logic [15:0] alu_a;
  logic [15:0] alu_b;
  logic        alu_inc;
  logic [15:0] alu_res;
  logic        alu_gt;
  logic        cfg_write;

  assign item_ready = (state == S_IDLE);
  assign cfg_ready  = (state == S_IDLE);
  assign cfg_write  = cfg_valid && cfg_ready;

  always_comb begin
    for (int i = 0; i < bse_pkg::NUM_BUTTONS; i++) begin
      if (i < bse_pkg::LEVEL_BITS) begin
        released_vec[i] = levels[i];
      end else begin
        released_vec[i] = 1'b1;
      end
    end
  end

  assign pressed   = !released_vec[idx];
  assign idx_last  = (idx == bse_pkg::BTN_IDX_W'(bse_pkg::NUM_BUTTONS - 1));
  assign idx_dir   = (idx < bse_pkg::BTN_IDX_W'(bse_pkg::NUM_DIRS));
  assign off_step  = (state == S_BTN) && !halt_due && pressed && !off_done &&
                     (idx == bse_pkg::BTN_IDX_W'(bse_pkg::OFF_BUTTON));
  assign menu_skip = dir_held && (idx == bse_pkg::BTN_IDX_W'(bse_pkg::MENU_BUTTON));

  always_comb begin
    alu_inc = 1'b1;
    alu_b   = off_hold_limit;
    if (state == S_TIMER) begin
      alu_a = timer_count;
      alu_b = tick_timer_limit;
    end else if (off_step) begin
      alu_a = off_hold_count;
    end else begin
      alu_a   = {8'd0, countdown[idx]};
      alu_inc = 1'b0;
    end
    if (!alu_inc) begin
      alu_res = alu_a - 16'd1;
    end else if (alu_a == 16'hFFFF) begin
      alu_res = alu_a;
    end else begin
      alu_res = alu_a + 16'd1;
    end
    alu_gt = (alu_res > alu_b);
  end

  always_comb begin
    push_req   = 1'b0;
    push_event = '{code: bse_pkg::CODE_WAKE, level: 1'b0, flush: 1'b0};
    unique case (state)
      S_WAKE: begin
        push_req         = 1'b1;
        push_event.flush = 1'b1;
      end
      S_BTN: begin
        if (halt_due) begin
          push_req        = 1'b1;
          push_event.code = bse_pkg::CODE_HALT;
        end else if (pressed && !off_step && !menu_skip && countdown[idx] == 8'd0) begin
          push_req        = 1'b1;
          push_event.code = screen ? bse_pkg::EVENT_CODE_W'(idx) : bse_pkg::CODE_SCREEN;
        end
      end
      S_TIMER: begin
        push_req        = tick_timer_enable && alu_gt;
        push_event.code = bse_pkg::CODE_TIMER;
      end
      S_USB: begin
        push_req         = levels_captured && (usb != usb_level_seen);
        push_event.code  = bse_pkg::CODE_USB;
        push_event.level = usb;
      end
      S_PWR: begin
        push_req         = pwr != power_level_seen;
        push_event.code  = bse_pkg::CODE_POWER;
        push_event.level = pwr;
      end
      default: begin
        push_req = 1'b0;
      end
    endcase
  end

  assign out_free = !event_valid || event_ready;
  assign can_push = !pend_valid || out_free;
  assign push_ok  = push_req && can_push;
  assign fin_load = (state == S_FIN) && pend_valid && out_free;
  assign out_load = (push_ok && pend_valid) || fin_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      repeat_reload     <= bse_pkg::RESET_REPEAT_RELOAD;
      off_hold_limit    <= bse_pkg::RESET_OFF_HOLD_LIMIT;
      tick_timer_enable <= 1'b0;
      tick_timer_limit  <= bse_pkg::RESET_TICK_TIMER_LIMIT;
      for (int i = 0; i < bse_pkg::NUM_BUTTONS; i++) begin
        countdown[i] <= 8'd0;
      end
      off_hold_count    <= 16'd0;
      timer_count       <= 16'd0;
      usb_level_seen    <= 1'b0;
      power_level_seen  <= 1'b0;
      levels_captured   <= 1'b0;
      idx               <= '0;
      dir_held          <= 1'b0;
      off_done          <= 1'b0;
      halt_due          <= 1'b0;
      pend_valid        <= 1'b0;
      event_valid       <= 1'b0;
    end else begin
      if (out_load) begin
        event_code   <= pend.code;
        new_level    <= pend.level;
        flush_queue  <= pend.flush;
        last_of_tick <= fin_load;
        event_valid  <= 1'b1;
      end else if (event_valid && event_ready) begin
        event_valid <= 1'b0;
      end
      if (push_ok) begin
        pend       <= push_event;
        pend_valid <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            levels   <= button_levels;
            screen   <= screen_on;
            usb      <= usb_present;
            pwr      <= power_present;
            idx      <= '0;
            dir_held <= 1'b0;
            off_done <= 1'b0;
            halt_due <= 1'b0;
            state    <= wake_request ? S_WAKE : S_BTN;
          end
        end
        S_WAKE: begin
          if (push_ok) begin
            state <= S_FIN;
          end
        end
        S_BTN: begin
          if (halt_due) begin
            if (push_ok) begin
              halt_due <= 1'b0;
            end
          end else if (!pressed) begin
            countdown[idx] <= 8'd0;
            if (idx == bse_pkg::BTN_IDX_W'(bse_pkg::OFF_BUTTON)) begin
              off_hold_count <= 16'd0;
            end
            if (idx_last) begin
              state <= S_TIMER;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (off_step) begin
            off_hold_count <= alu_res;
            halt_due       <= alu_gt;
            off_done       <= 1'b1;
          end else if (menu_skip) begin
            if (idx_last) begin
              state <= S_TIMER;
            end else begin
              idx <= idx + 1'b1;
            end
          end else if (countdown[idx] == 8'd0) begin
            if (push_ok) begin
              countdown[idx] <= repeat_reload;
              if (!screen) begin
                state <= S_TIMER;
              end else begin
                if (idx_dir) begin
                  dir_held <= 1'b1;
                end
                if (idx_last) begin
                  state <= S_TIMER;
                end else begin
                  idx <= idx + 1'b1;
                end
              end
            end
          end else begin
            countdown[idx] <= alu_res[7:0];
            if (idx_dir) begin
              dir_held <= 1'b1;
            end
            if (idx_last) begin
              state <= S_TIMER;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_TIMER: begin
          if (!tick_timer_enable) begin
            state <= S_USB;
          end else if (!alu_gt) begin
            timer_count <= alu_res;
            state       <= S_USB;
          end else if (push_ok) begin
            timer_count <= 16'd0;
            state       <= S_USB;
          end
        end
        S_USB: begin
          if (!levels_captured) begin
            usb_level_seen   <= usb;
            power_level_seen <= pwr;
            levels_captured  <= 1'b1;
            state            <= S_FIN;
          end else if (!push_req || push_ok) begin
            usb_level_seen <= usb;
            state          <= S_PWR;
          end
        end
        S_PWR: begin
          if (!push_req || push_ok) begin
            power_level_seen <= pwr;
            state            <= S_FIN;
          end
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (cfg_write) begin
        unique case (cfg_index)
          bse_pkg::REG_REPEAT_RELOAD: begin
            repeat_reload <= cfg_data[7:0];
          end
          bse_pkg::REG_OFF_HOLD_LIMIT: begin
            off_hold_limit <= cfg_data;
          end
          bse_pkg::REG_TICK_TIMER_ENABLE: begin
            tick_timer_enable <= cfg_data[0];
            timer_count       <= 16'd0;
          end
          bse_pkg::REG_TICK_TIMER_LIMIT: begin
            tick_timer_limit <= cfg_data;
            timer_count      <= 16'd0;
          end
          default: begin
            repeat_reload <= repeat_reload;
          end
        endcase
      end
    end
  end

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> !pend_valid)
    else $error("Pending event left over while the block is idle.");

  a_flush_is_last: assert property (@(posedge clk) disable iff (rst)
    event_valid && flush_queue |-> last_of_tick && event_code == bse_pkg::CODE_WAKE)
    else $error("Wake event is not the sole event of its tick.");

  a_timer_write_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_write && (cfg_index == bse_pkg::REG_TICK_TIMER_ENABLE ||
                  cfg_index == bse_pkg::REG_TICK_TIMER_LIMIT) |=> timer_count == 16'd0)
    else $error("Timer count not cleared by a timer register write.");

  a_halt_only_when_held: assert property (@(posedge clk) disable iff (rst)
    halt_due |-> off_hold_count > off_hold_limit)
    else $error("Halt event raised while off hold count is within its limit.");

endmodule

### test/button_scanner_autorepeat_events_top_test.sv
// Self-checking testbench for the button scanner with autorepeat and event generation.
module button_scanner_autorepeat_events_top_test;

  localparam int CYCLE_LIMIT   = 600000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int STALL_CYCLES  = 300;
  localparam int PHASES        = 7;
  localparam int PHASE_TICKS   = 40;
  localparam int CALM_PHASE    = 2;
  localparam int STALL_PHASE   = 3;
  localparam int PAUSE_PHASE   = 4;

  typedef struct packed {
    logic [bse_pkg::LEVEL_BITS-1:0] levels;
    logic                           screen;
    logic                           usb;
    logic                           pwr;
    logic                           wake;
  } poll_t;

  typedef struct packed {
    logic [bse_pkg::EVENT_CODE_W-1:0] code;
    logic                             level;
    logic                             flush;
    logic                             last;
  } event_rec_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_TYPED_QUIET,
    ROW_TYPED_ONE,
    ROW_SETTINGS
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    poll_t       poll;
    event_rec_t  typed_ev;
    logic [7:0]  reload;
    logic [15:0] off_limit;
    logic        timer_on;
    logic [15:0] timer_limit;
  } row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             item_valid = 1'b0;
  logic                             item_ready;
  logic [bse_pkg::LEVEL_BITS-1:0]   button_levels = '1;
  logic                             screen_on = 1'b1;
  logic                             usb_present = 1'b0;
  logic                             power_present = 1'b0;
  logic                             wake_request = 1'b0;
  logic                             event_valid;
  logic                             event_ready = 1'b0;
  logic [bse_pkg::EVENT_CODE_W-1:0] event_code;
  logic                             new_level;
  logic                             flush_queue;
  logic                             last_of_tick;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [bse_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [bse_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

  logic [7:0]  cfg_reload;
  logic [15:0] cfg_off_limit;
  logic        cfg_timer_on;
  logic [15:0] cfg_timer_limit;
  logic [7:0]  repeat_left [bse_pkg::NUM_BUTTONS];
  logic [15:0] hold9_ticks;
  logic [15:0] timer_ticks;
  logic        usb_seen;
  logic        power_seen;
  logic        levels_known;

  event_rec_t  tick_events [$];
  event_rec_t  awaited_events [$];
  row_t        directed_rows [$];

  logic [bse_pkg::LEVEL_BITS-1:0] held_buttons = '0;
  logic        usb_drive = 1'b0;
  logic        power_drive = 1'b0;
  bit          calm = 1'b0;
  bit          stall_request = 1'b0;
  int          stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  button_scanner_autorepeat_events_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .button_levels (button_levels),
    .screen_on     (screen_on),
    .usb_present   (usb_present),
    .power_present (power_present),
    .wake_request  (wake_request),
    .event_valid   (event_valid),
    .event_ready   (event_ready),
    .event_code    (event_code),
    .new_level     (new_level),
    .flush_queue   (flush_queue),
    .last_of_tick  (last_of_tick),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  function automatic void add_event(input logic [bse_pkg::EVENT_CODE_W-1:0] code,
                                    input logic level, input logic flush);
    tick_events.push_back({code, level, flush, 1'b0});
  endfunction

  function automatic void write_register(input logic [bse_pkg::CFG_INDEX_W-1:0] idx,
                                         input logic [bse_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bse_pkg::REG_REPEAT_RELOAD: begin
        cfg_reload = data[7:0];
      end
      bse_pkg::REG_OFF_HOLD_LIMIT: begin
        cfg_off_limit = data;
      end
      bse_pkg::REG_TICK_TIMER_ENABLE: begin
        cfg_timer_on = data[0];
        timer_ticks  = '0;
      end
      bse_pkg::REG_TICK_TIMER_LIMIT: begin
        cfg_timer_limit = data;
        timer_ticks     = '0;
      end
      default: begin
      end
    endcase
  endfunction

  // Works out the events of one poll tick and advances the scanner state.
  function automatic void scan_poll_tick(input poll_t p);
    logic                             dir_held;
    logic                             pressed;
    logic [bse_pkg::EVENT_CODE_W-1:0] btn_code;
    tick_events.delete();
    if (p.wake) begin
      add_event(bse_pkg::CODE_WAKE, 1'b0, 1'b1);
      return;
    end
    dir_held = 1'b0;
    for (int b = 0; b < bse_pkg::NUM_BUTTONS; b++) begin
      pressed = (b < bse_pkg::LEVEL_BITS) && !p.levels[b];
      if (!pressed) begin
        repeat_left[b] = '0;
        if (b == bse_pkg::OFF_BUTTON) begin
          hold9_ticks = '0;
        end
        continue;
      end
      if (b == bse_pkg::OFF_BUTTON) begin
        if (hold9_ticks != 16'hFFFF) begin
          hold9_ticks++;
        end
        if (hold9_ticks > cfg_off_limit) begin
          add_event(bse_pkg::CODE_HALT, 1'b0, 1'b0);
        end
      end
      if (b == bse_pkg::MENU_BUTTON && dir_held) begin
        continue;
      end
      if (repeat_left[b] == '0) begin
        repeat_left[b] = cfg_reload;
        if (!p.screen) begin
          add_event(bse_pkg::CODE_SCREEN, 1'b0, 1'b0);
          break;
        end
        btn_code = b[bse_pkg::EVENT_CODE_W-1:0];
        add_event(btn_code, 1'b0, 1'b0);
      end else begin
        repeat_left[b]--;
      end
      if (b < bse_pkg::NUM_DIRS) begin
        dir_held = 1'b1;
      end
    end
    if (cfg_timer_on) begin
      if (timer_ticks != 16'hFFFF) begin
        timer_ticks++;
      end
      if (timer_ticks > cfg_timer_limit) begin
        add_event(bse_pkg::CODE_TIMER, 1'b0, 1'b0);
        timer_ticks = '0;
      end
    end
    if (!levels_known) begin
      usb_seen     = p.usb;
      power_seen   = p.pwr;
      levels_known = 1'b1;
    end
    if (p.usb != usb_seen) begin
      usb_seen = p.usb;
      add_event(bse_pkg::CODE_USB, p.usb, 1'b0);
    end
    if (p.pwr != power_seen) begin
      power_seen = p.pwr;
      add_event(bse_pkg::CODE_POWER, p.pwr, 1'b0);
    end
  endfunction

  function automatic poll_t random_poll();
    poll_t p;
    if ($urandom_range(0, 9) == 0) begin
      p.levels = bse_pkg::LEVEL_BITS'($urandom_range(0, (1 << bse_pkg::LEVEL_BITS) - 1));
      p.screen = 1'($urandom_range(0, 1));
      p.usb    = 1'($urandom_range(0, 1));
      p.pwr    = 1'($urandom_range(0, 1));
      p.wake   = 1'($urandom_range(0, 1));
    end else begin
      for (int b = 0; b < bse_pkg::LEVEL_BITS; b++) begin
        if ($urandom_range(0, 7) == 0) begin
          held_buttons[b] = ~held_buttons[b];
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        usb_drive = ~usb_drive;
      end
      if ($urandom_range(0, 9) == 0) begin
        power_drive = ~power_drive;
      end
      p.levels = ~held_buttons;
      p.screen = $urandom_range(0, 7) != 0;
      p.usb    = usb_drive;
      p.pwr    = power_drive;
      p.wake   = $urandom_range(0, 19) == 0;
    end
    return p;
  endfunction

  function automatic row_t poll_row(input row_kind_t kind,
                                    input logic [bse_pkg::LEVEL_BITS-1:0] levels,
                                    input logic screen, input logic usb, input logic pwr,
                                    input logic wake,
                                    input logic [bse_pkg::EVENT_CODE_W-1:0] code,
                                    input logic level, input logic flush);
    row_t r;
    r = '0;
    r.kind     = kind;
    r.poll     = {levels, screen, usb, pwr, wake};
    r.typed_ev = {code, level, flush, 1'b1};
    return r;
  endfunction

  function automatic row_t settings_row(input logic [7:0] reload, input logic [15:0] off_limit,
                                        input logic timer_on, input logic [15:0] timer_limit);
    row_t r;
    r = '0;
    r.kind        = ROW_SETTINGS;
    r.reload      = reload;
    r.off_limit   = off_limit;
    r.timer_on    = timer_on;
    r.timer_limit = timer_limit;
    return r;
  endfunction

  task automatic offer_tick(input poll_t p, input row_kind_t kind, input event_rec_t typed_ev);
    int unsigned gap;
    event_rec_t  rec;
    if (!calm && $urandom_range(0, 99) < 31) begin
      gap = $urandom_range(1, 20);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid    <= 1'b1;
    button_levels <= p.levels;
    screen_on     <= p.screen;
    usb_present   <= p.usb;
    power_present <= p.pwr;
    wake_request  <= p.wake;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    scan_poll_tick(p);
    if (kind == ROW_TYPED_ONE) begin
      awaited_events.push_back(typed_ev);
    end else if (kind == ROW_PREDICT) begin
      for (int k = 0; k < tick_events.size(); k++) begin
        rec      = tick_events[k];
        rec.last = (k == tick_events.size() - 1);
        awaited_events.push_back(rec);
      end
    end
  endtask

  task automatic wait_until_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (awaited_events.size() != 0) @(posedge clk);
  endtask

  task automatic send_register(input logic [bse_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [bse_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    write_register(idx, data);
  endtask

  // Registers are only written once the block has gone quiet.
  task automatic apply_settings(input logic [7:0] reload, input logic [15:0] off_limit,
                                input logic timer_on, input logic [15:0] timer_limit);
    logic [7:0]  reload_pad;
    logic [14:0] enable_pad;
    reload_pad = 8'($urandom_range(0, 255));
    enable_pad = 15'($urandom_range(0, 32767));
    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    send_register(bse_pkg::REG_REPEAT_RELOAD, {reload_pad, reload});
    send_register(bse_pkg::REG_OFF_HOLD_LIMIT, off_limit);
    send_register(bse_pkg::REG_TICK_TIMER_ENABLE, {enable_pad, timer_on});
    send_register(bse_pkg::REG_TICK_TIMER_LIMIT, timer_limit);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_request) begin
      stall_left    = STALL_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      event_ready <= 1'b0;
    end else if (calm) begin
      event_ready <= 1'b1;
    end else begin
      event_ready <= $urandom_range(0, 99) >= 31;
    end
  end

  always @(posedge clk) begin
    event_rec_t want;
    if (!rst && event_valid && event_ready) begin
      if (awaited_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event, code %0d", event_code));
      end else begin
        want = awaited_events.pop_front();
        if (event_code !== want.code) begin
          report_mismatch($sformatf("event_code %0d, wanted %0d", event_code, want.code));
        end
        if (new_level !== want.level) begin
          report_mismatch($sformatf("new_level %b, wanted %b (code %0d)",
                                    new_level, want.level, want.code));
        end
        if (flush_queue !== want.flush) begin
          report_mismatch($sformatf("flush_queue %b, wanted %b (code %0d)",
                                    flush_queue, want.flush, want.code));
        end
        if (last_of_tick !== want.last) begin
          report_mismatch($sformatf("last_of_tick %b, wanted %b (code %0d)",
                                    last_of_tick, want.last, want.code));
        end
      end
    end
  end

  initial begin
    row_t r;
    cfg_reload      = bse_pkg::RESET_REPEAT_RELOAD;
    cfg_off_limit   = bse_pkg::RESET_OFF_HOLD_LIMIT;
    cfg_timer_on    = 1'b0;
    cfg_timer_limit = bse_pkg::RESET_TICK_TIMER_LIMIT;
    for (int b = 0; b < bse_pkg::NUM_BUTTONS; b++) begin
      repeat_left[b] = '0;
    end
    hold9_ticks  = '0;
    timer_ticks  = '0;
    usb_seen     = 1'b0;
    power_seen   = 1'b0;
    levels_known = 1'b0;

    directed_rows.push_back(poll_row(ROW_TYPED_ONE, '1, 1'b1, 1'b1, 1'b1, 1'b1,
                                     bse_pkg::CODE_WAKE, 1'b0, 1'b1));
    directed_rows.push_back(poll_row(ROW_TYPED_QUIET, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_TYPED_ONE, '1, 1'b1, 1'b0, 1'b1, 1'b0,
                                     bse_pkg::CODE_USB, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_TYPED_ONE, '1, 1'b1, 1'b0, 1'b0, 1'b0,
                                     bse_pkg::CODE_POWER, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_TYPED_ONE, 10'h3FE, 1'b1, 1'b0, 1'b0, 1'b0,
                                     4'd0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, 10'h3EE, 1'b1, 1'b0, 1'b0, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, 10'h3EF, 1'b1, 1'b0, 1'b0, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_TYPED_ONE, 10'h3DF, 1'b0, 1'b0, 1'b0, 1'b0,
                                     bse_pkg::CODE_SCREEN, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, '0, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_TYPED_ONE, '0, 1'b0, 1'b0, 1'b0, 1'b1,
                                     bse_pkg::CODE_WAKE, 1'b0, 1'b1));
    directed_rows.push_back(poll_row(ROW_PREDICT, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(settings_row(8'd0, 16'd0, 1'b1, 16'd0));
    directed_rows.push_back(poll_row(ROW_PREDICT, 10'h1FF, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, 10'h1FF, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, '0, 1'b0, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, '1, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(settings_row(8'd255, 16'hFFFF, 1'b1, 16'hFFFF));
    directed_rows.push_back(poll_row(ROW_PREDICT, '0, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, '0, 1'b1, 1'b1, 1'b1, 1'b0,
                                     '0, 1'b0, 1'b0));
    directed_rows.push_back(poll_row(ROW_PREDICT, '1, 1'b1, 1'b0, 1'b0, 1'b0,
                                     '0, 1'b0, 1'b0));

    rst <= 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      r = directed_rows[n];
      if (r.kind == ROW_SETTINGS) begin
        apply_settings(r.reload, r.off_limit, r.timer_on, r.timer_limit);
      end else begin
        offer_tick(r.poll, r.kind, r.typed_ev);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: apply_settings(8'd0, 16'd0, 1'b1, 16'd0);
        1: apply_settings(8'd255, 16'hFFFF, 1'b0, 16'hFFFF);
        default: apply_settings(8'($urandom_range(0, 4)), 16'($urandom_range(0, 12)),
                                1'($urandom_range(0, 1)), 16'($urandom_range(0, 6)));
      endcase
      calm = (ph == CALM_PHASE);
      if (ph == STALL_PHASE) begin
        stall_request = 1'b1;
      end
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (ph == PAUSE_PHASE && k == PHASE_TICKS / 2) begin
          wait_until_drained();
        end
        offer_tick(random_poll(), ROW_PREDICT, '0);
      end
    end
    calm = 1'b0;

    wait_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
